@@ rtl/gre_pkg.sv @@
// gre_pkg: shared types and constants of the gamepad report event generator
// depends on: nothing

package gre_pkg;

    localparam int BUTTONS     = 24;
    localparam int AXES        = 6;
    localparam int KEY_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int STICK_ROW_W = 80;

    localparam logic [KEY_W-1:0] LAST_AXIS   = KEY_W'(AXES - 1);
    localparam logic [KEY_W-1:0] LAST_BUTTON = KEY_W'(BUTTONS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_DZ     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DZ    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEXT_DELAY  = 3'd4;

    // register reset values
    localparam logic [14:0] LEFT_DZ_RST     = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RST    = 15'd8689;
    localparam logic [7:0]  TRIG_THR_RST    = 8'd30;
    localparam logic [15:0] FIRST_DELAY_RST = 16'd200;
    localparam logic [15:0] NEXT_DELAY_RST  = 16'd100;

    typedef enum logic [2:0] {
        EV_CONNECT    = 3'd0,
        EV_DISCONNECT = 3'd1,
        EV_ANALOG     = 3'd2,
        EV_PRESS      = 3'd3,
        EV_RELEASE    = 3'd4,
        EV_REPEAT     = 3'd5
    } event_kind_t;

    typedef struct packed {
        logic [14:0] left_dz;
        logic [14:0] right_dz;
        logic [7:0]  trig_thr;
        logic [15:0] first_delay;
        logic [15:0] next_delay;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         pad;
        logic               connected;
        logic [15:0]        button_word;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [31:0]        now;
    } report_t;

    typedef struct packed {
        logic [1:0]         pad;
        event_kind_t        kind;
        logic [KEY_W-1:0]   key;
        logic signed [15:0] value;
    } evt_t;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             conn;
        logic             ana;
        logic             btn;
        logic             flush;
        logic             adv;
        logic [KEY_W-1:0] idx;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic hit;
        logic slot_free;
        logic pend_valid;
        logic out_free;
    } ctl_status_t;

endpackage

@@ rtl/gre_report_if.sv @@
// gre_report_if: poll report channel, valid/ready handshake
// depends on: nothing

interface gre_report_if;
    logic               valid;
    logic               ready;
    logic [1:0]         pad;
    logic               connected;
    logic [15:0]        button_word;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [31:0]        now;

    modport source (
        output valid, pad, connected, button_word, left_trigger, right_trigger,
        output left_x, left_y, right_x, right_y, now,
        input  ready
    );
    modport sink (
        input  valid, pad, connected, button_word, left_trigger, right_trigger,
        input  left_x, left_y, right_x, right_y, now,
        output ready
    );
endinterface

@@ rtl/gre_event_if.sv @@
// gre_event_if: event channel, valid/ready handshake
// depends on: nothing

interface gre_event_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_pad;
    logic [2:0]         event_kind;
    logic [4:0]         key;
    logic signed [15:0] axis_value;
    logic               last;

    modport source (
        output valid, event_pad, event_kind, key, axis_value, last,
        input  ready
    );
    modport sink (
        input  valid, event_pad, event_kind, key, axis_value, last,
        output ready
    );
endinterface

@@ rtl/gre_cfg_if.sv @@
// gre_cfg_if: configuration write channel, valid/ready handshake
// depends on: nothing

interface gre_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/gamepad_report_event_generator.sv @@
// gamepad_report_event_generator: top level, poll reports in, pad events out
// depends on: gre_pkg, gre_report_if, gre_event_if, gre_cfg_if, gre_cfg, gre_ctl, gre_dp
//
// sequence per report: accept, connection step, each axis, each button, then flush;
//   a new report is accepted only once the previous one has been flushed;
//   a report for a pad that is offline and was offline is dropped at accept; a stalled event holds the scan
// events: each event waits in the hold stage for the next one or the flush, then moves to the
//   output register; the event moved at flush carries the last flag
// reset: rst_n clears connection flags, button levels, axis history valid
//   bits and the event stages at once, and loads register defaults; no clearing pass

module gamepad_report_event_generator #(
    parameter int PADS      = 4,
    parameter int TIME_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    gre_report_if.sink    report,
    gre_event_if.source   events,
    gre_cfg_if.sink       cfg
);
    import gre_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;
    cfg_t        cfg_val;
    report_t     rpt;
    evt_t        out_evt;
    logic        in_ready;

    // registers may be written at any time the block is idle
    assign cfg.ready = 1'b1;

    gre_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg.valid),
        .wr_idx  (cfg.index),
        .wr_data (cfg.data),
        .cfg     (cfg_val)
    );

    // pack the report item for the datapath
    assign rpt.pad           = report.pad;
    assign rpt.connected     = report.connected;
    assign rpt.button_word   = report.button_word;
    assign rpt.left_trigger  = report.left_trigger;
    assign rpt.right_trigger = report.right_trigger;
    assign rpt.left_x        = report.left_x;
    assign rpt.left_y        = report.left_y;
    assign rpt.right_x       = report.right_x;
    assign rpt.right_y       = report.right_y;
    assign rpt.now           = report.now;

    assign report.ready = in_ready;

    // sequencer: walks connection, axes and buttons of one report
    gre_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (report.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: per-pad history, repeat timers, event hold and output register;
    // one event is held back so that the last flag can be set at flush
    gre_dp #(
        .PADS      (PADS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg_val),
        .rpt       (rpt),
        .out_valid (events.valid),
        .out_ready (events.ready),
        .out_evt   (out_evt),
        .out_last  (events.last)
    );

    assign events.event_pad  = out_evt.pad;
    assign events.event_kind = out_evt.kind;
    assign events.key        = out_evt.key;
    assign events.axis_value = out_evt.value;
endmodule

@@ rtl/gre_ram.sv @@
// gre_ram: generic simple dual-port ram, one write and one registered read port
// depends on: nothing

module gre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/gre_cfg.sv @@
// gre_cfg: configuration register file with decode of the write index
// depends on: gre_pkg

module gre_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [gre_pkg::CFG_IDX_W-1:0]  wr_idx,
    input  logic [gre_pkg::CFG_DATA_W-1:0] wr_data,
    output gre_pkg::cfg_t                  cfg
);
    import gre_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_dz     <= LEFT_DZ_RST;
            cfg_reg.right_dz    <= RIGHT_DZ_RST;
            cfg_reg.trig_thr    <= TRIG_THR_RST;
            cfg_reg.first_delay <= FIRST_DELAY_RST;
            cfg_reg.next_delay  <= NEXT_DELAY_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_LEFT_DZ:     cfg_reg.left_dz     <= wr_data[14:0];
                REG_RIGHT_DZ:    cfg_reg.right_dz    <= wr_data[14:0];
                REG_TRIG_THR:    cfg_reg.trig_thr    <= wr_data[7:0];
                REG_FIRST_DELAY: cfg_reg.first_delay <= wr_data;
                REG_NEXT_DELAY:  cfg_reg.next_delay  <= wr_data;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

@@ rtl/gre_ctl.sv @@
// gre_ctl: sequencer for one report: connection, six axes, 24 buttons, flush
// depends on: gre_pkg

module gre_ctl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gre_pkg::ctl_status_t status,
    output gre_pkg::ctl_cmd_t    cmd
);
    import gre_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONN,
        S_ANA,
        S_BTN,
        S_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [KEY_W-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!status.skip)
                    begin
                        state_next = S_CONN;
                    end
                end
            end
            S_CONN:
            begin
                cmd.conn   = 1'b1;
                idx_next   = '0;
                state_next = S_ANA;
            end
            S_ANA:
            begin
                cmd.ana = 1'b1;
                cmd.adv = !status.hit || status.slot_free;
                if (cmd.adv)
                begin
                    if (idx_reg == LAST_AXIS)
                    begin
                        idx_next   = '0;
                        state_next = S_BTN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_BTN:
            begin
                cmd.btn = 1'b1;
                cmd.adv = !status.hit || status.slot_free;
                if (cmd.adv)
                begin
                    if (idx_reg == LAST_BUTTON)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                cmd.flush = 1'b1;
                cmd.adv   = !status.pend_valid || status.out_free;
                if (cmd.adv)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end
endmodule

@@ rtl/gre_dp.sv @@
// gre_dp: per-pad state, axis and button evaluation, event hold and output stage
// depends on: gre_pkg, gre_ram

module gre_dp #(
    parameter int PADS      = 4,
    parameter int TIME_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gre_pkg::ctl_cmd_t    cmd,
    output gre_pkg::ctl_status_t status,
    input  gre_pkg::cfg_t        cfg,
    input  gre_pkg::report_t     rpt,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gre_pkg::evt_t        out_evt,
    output logic                 out_last
);
    import gre_pkg::*;

    localparam int PAD_AW = (PADS > 1) ? $clog2(PADS) : 1;
    localparam int DUE_D  = PADS * BUTTONS;
    localparam int DUE_AW = (DUE_D > 1) ? $clog2(DUE_D) : 1;

    function automatic logic above(input logic signed [15:0] v, input logic [14:0] dz);
        logic signed [16:0] v17;
        logic signed [16:0] dz17;
        v17  = {v[15], v};
        dz17 = {2'b00, dz};
        return v17 > dz17;
    endfunction

    function automatic logic below(input logic signed [15:0] v, input logic [14:0] dz);
        logic signed [16:0] v17;
        logic signed [16:0] dz17;
        v17  = {v[15], v};
        dz17 = {2'b00, dz};
        return v17 < -dz17;
    endfunction

    // per-pad control state
    logic [PADS-1:0] was_conn_reg;
    logic [PADS-1:0] stick_ok_reg;
    logic [23:0]     levels_arr_reg [PADS];

    // latched report
    logic [1:0]           pad_reg;
    logic                 cur_reg;
    logic                 was_reg;
    logic                 old_ok_reg;
    logic [23:0]          lvl_reg;
    logic [23:0]          prev_reg;
    logic signed [15:0]   ax_reg [4];
    logic [7:0]           trg_reg [2];
    logic [TIME_BITS-1:0] now_reg;

    // event hold stage and output register
    logic pend_valid_reg;
    evt_t pend_reg;
    logic out_valid_reg;
    evt_t out_reg;
    logic out_last_reg;

    // load side
    logic               in_range;
    logic [PAD_AW-1:0]  in_pidx;
    logic               in_was;
    logic [15:0]        m_bw;
    logic [7:0]         m_lt;
    logic [7:0]         m_rt;
    logic signed [15:0] m_lx;
    logic signed [15:0] m_ly;
    logic signed [15:0] m_rx;
    logic signed [15:0] m_ry;
    logic [23:0]        lvl_in;

    assign in_range = ({30'd0, rpt.pad} < 32'(PADS));
    assign in_pidx  = PAD_AW'(rpt.pad);
    assign in_was   = was_conn_reg[in_pidx];

    // a disconnected pad reads as all zeros
    assign m_bw = rpt.connected ? rpt.button_word   : '0;
    assign m_lt = rpt.connected ? rpt.left_trigger  : '0;
    assign m_rt = rpt.connected ? rpt.right_trigger : '0;
    assign m_lx = rpt.connected ? rpt.left_x        : '0;
    assign m_ly = rpt.connected ? rpt.left_y        : '0;
    assign m_rx = rpt.connected ? rpt.right_x       : '0;
    assign m_ry = rpt.connected ? rpt.right_y       : '0;

    // logical button map, back and start swapped
    always_comb
    begin
        lvl_in[0]  = m_bw[12];
        lvl_in[1]  = m_bw[13];
        lvl_in[2]  = m_bw[14];
        lvl_in[3]  = m_bw[15];
        lvl_in[4]  = m_bw[8];
        lvl_in[5]  = m_bw[9];
        lvl_in[6]  = m_bw[4];
        lvl_in[7]  = m_bw[5];
        lvl_in[8]  = m_bw[6];
        lvl_in[9]  = m_bw[7];
        lvl_in[10] = m_lt > cfg.trig_thr;
        lvl_in[11] = m_rt > cfg.trig_thr;
        lvl_in[12] = m_bw[0];
        lvl_in[13] = m_bw[1];
        lvl_in[14] = m_bw[2];
        lvl_in[15] = m_bw[3];
        lvl_in[16] = above(m_ly, cfg.left_dz);
        lvl_in[17] = below(m_ly, cfg.left_dz);
        lvl_in[18] = below(m_lx, cfg.left_dz);
        lvl_in[19] = above(m_lx, cfg.left_dz);
        lvl_in[20] = above(m_ry, cfg.right_dz);
        lvl_in[21] = below(m_ry, cfg.right_dz);
        lvl_in[22] = below(m_rx, cfg.right_dz);
        lvl_in[23] = above(m_rx, cfg.right_dz);
    end

    logic [PAD_AW-1:0] pidx;
    assign pidx = PAD_AW'(pad_reg);

    // previous axis values, one row per pad
    logic                   stick_we;
    logic [STICK_ROW_W-1:0] stick_wdata;
    logic [STICK_ROW_W-1:0] stick_rdata;

    assign stick_we    = cmd.ana && cmd.adv && (cmd.idx == LAST_AXIS);
    assign stick_wdata = {trg_reg[1], trg_reg[0], ax_reg[3], ax_reg[2], ax_reg[1], ax_reg[0]};

    gre_ram #(
        .WIDTH (STICK_ROW_W),
        .DEPTH (PADS)
    ) u_stick_ram (
        .clk   (clk),
        .we    (stick_we),
        .waddr (pidx),
        .wdata (stick_wdata),
        .re    (cmd.load),
        .raddr (in_pidx),
        .rdata (stick_rdata)
    );

    // axis evaluation
    logic signed [15:0] old_ax [4];
    logic [7:0]         old_trg [2];
    logic               ana_hit;
    logic signed [15:0] ana_val;
    logic [14:0]        ana_dz;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            old_ax[k] = old_ok_reg ? stick_rdata[16*k +: 16] : '0;
        end
        for (int k = 0; k < 2; k++)
        begin
            old_trg[k] = old_ok_reg ? stick_rdata[64 + 8*k +: 8] : '0;
        end
    end

    always_comb
    begin
        ana_dz = cmd.idx[1] ? cfg.right_dz : cfg.left_dz;
        if (cmd.idx < KEY_W'(4))
        begin
            ana_val = ax_reg[cmd.idx[1:0]];
            ana_hit = (ana_val != old_ax[cmd.idx[1:0]])
                      || above(ana_val, ana_dz) || below(ana_val, ana_dz);
        end
        else
        begin
            ana_val = {8'd0, trg_reg[cmd.idx[0]]};
            ana_hit = (trg_reg[cmd.idx[0]] != old_trg[cmd.idx[0]])
                      || (trg_reg[cmd.idx[0]] > cfg.trig_thr);
        end
    end

    // repeat due times; a due time is only read for a held button, which
    // was written at its press, so the ram needs no clearing
    logic [DUE_AW-1:0]    due_base;
    logic                 due_we;
    logic [DUE_AW-1:0]    due_waddr;
    logic [TIME_BITS-1:0] due_wdata;
    logic                 due_re;
    logic [DUE_AW-1:0]    due_raddr;
    logic [TIME_BITS-1:0] due_rdata;
    logic [TIME_BITS-1:0] due_diff;
    logic                 btn_c;
    logic                 btn_p;
    logic                 btn_edge;
    logic                 btn_hit;

    assign due_base  = DUE_AW'(32'(pidx) * BUTTONS);
    assign btn_c     = lvl_reg[cmd.idx];
    assign btn_p     = prev_reg[cmd.idx];
    assign btn_edge  = btn_c != btn_p;
    assign due_diff  = now_reg - due_rdata;
    assign btn_hit   = btn_edge || (btn_c && !due_diff[TIME_BITS-1]);

    assign due_we    = cmd.btn && cmd.adv && btn_c && btn_hit;
    assign due_waddr = due_base + DUE_AW'(cmd.idx);
    assign due_wdata = now_reg + (btn_edge ? TIME_BITS'(cfg.first_delay)
                                           : TIME_BITS'(cfg.next_delay));

    // prefetch the next button's due time as the scan moves on
    assign due_re    = (cmd.ana && cmd.adv && (cmd.idx == LAST_AXIS))
                       || (cmd.btn && cmd.adv && (cmd.idx != LAST_BUTTON));
    assign due_raddr = cmd.btn ? (due_base + DUE_AW'(cmd.idx) + DUE_AW'(1)) : due_base;

    gre_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DUE_D)
    ) u_due_ram (
        .clk   (clk),
        .we    (due_we),
        .waddr (due_waddr),
        .wdata (due_wdata),
        .re    (due_re),
        .raddr (due_raddr),
        .rdata (due_rdata)
    );

    // new event selection
    logic push;
    evt_t new_evt;
    logic out_free;
    logic out_load;

    always_comb
    begin
        new_evt.pad   = pad_reg;
        new_evt.kind  = EV_ANALOG;
        new_evt.key   = cmd.idx;
        new_evt.value = '0;
        push          = 1'b0;
        if (cmd.conn)
        begin
            new_evt.kind = cur_reg ? EV_CONNECT : EV_DISCONNECT;
            new_evt.key  = '0;
            push         = cur_reg != was_reg;
        end
        else if (cmd.ana)
        begin
            new_evt.value = ana_val;
            push          = cmd.adv && ana_hit;
        end
        else if (cmd.btn)
        begin
            if (btn_edge)
            begin
                new_evt.kind = btn_c ? EV_PRESS : EV_RELEASE;
            end
            else
            begin
                new_evt.kind = EV_REPEAT;
            end
            push = cmd.adv && btn_hit;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // held event moves to the output register when a new one arrives or at flush
    assign out_load = pend_valid_reg && (push || (cmd.flush && cmd.adv));

    assign status.skip       = !in_range || (!rpt.connected && !in_was);
    assign status.hit        = cmd.ana ? ana_hit : btn_hit;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;
    assign status.slot_free  = !pend_valid_reg || out_free;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_conn_reg   <= '0;
            stick_ok_reg   <= '0;
            levels_arr_reg <= '{default: '0};
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load && in_range)
            begin
                was_conn_reg[in_pidx] <= rpt.connected;
            end
            if (stick_we)
            begin
                stick_ok_reg[pidx] <= 1'b1;
            end
            if (cmd.btn && cmd.adv && (cmd.idx == LAST_BUTTON))
            begin
                levels_arr_reg[pidx] <= lvl_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (push)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush && cmd.adv)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pad_reg    <= rpt.pad;
            cur_reg    <= rpt.connected;
            was_reg    <= in_was;
            old_ok_reg <= stick_ok_reg[in_pidx];
            lvl_reg    <= lvl_in;
            prev_reg   <= levels_arr_reg[in_pidx];
            ax_reg[0]  <= m_lx;
            ax_reg[1]  <= m_ly;
            ax_reg[2]  <= m_rx;
            ax_reg[3]  <= m_ry;
            trg_reg[0] <= m_lt;
            trg_reg[1] <= m_rt;
            now_reg    <= TIME_BITS'(rpt.now);
        end
        if (push)
        begin
            pend_reg <= new_evt;
        end
        if (out_load)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_evt   = out_reg;
    assign out_last  = out_last_reg;
endmodule

@@ test/gamepad_report_event_generator_tb.sv @@
// gamepad_report_event_generator_tb: self-checking bench for the pad report event generator
// predicts connect, disconnect, analog, edge and auto-repeat events per report and checks each event
// depends on: gre_pkg, gre_report_if, gre_event_if, gre_cfg_if, gamepad_report_event_generator
`timescale 1ns / 100ps

module gamepad_report_event_generator_tb;
    import gre_pkg::*;

    localparam int PAD_COUNT    = 4;
    localparam int TIME_W       = 32;
    localparam int SETTLE_WAIT  = 40;      // block drains within a report time
    localparam int HOLD_CYCLES  = 400;     // long event-side hold-off
    localparam int CYCLE_LIMIT  = 400000;
    localparam int STICK_AXES   = 4;

    // one expected or observed event
    typedef struct packed {
        logic [1:0]         pad;
        event_kind_t        kind;
        logic [KEY_W-1:0]   key;
        logic signed [15:0] value;
        logic               last;
    } pad_event_t;

    logic clk;
    logic rst_n;

    gre_report_if report_bus ();
    gre_event_if  event_bus ();
    gre_cfg_if    cfg_bus ();

    gamepad_report_event_generator #(
        .PADS      (PAD_COUNT),
        .TIME_BITS (TIME_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .report (report_bus),
        .events (event_bus),
        .cfg    (cfg_bus)
    );

    // ------------------------------------------------------------------
    // predictor state: own copy of the registers and of every pad's history
    // ------------------------------------------------------------------
    cfg_t shadow_cfg = '{LEFT_DZ_RST, RIGHT_DZ_RST, TRIG_THR_RST, FIRST_DELAY_RST,
                         NEXT_DELAY_RST};

    bit                pad_online   [PAD_COUNT];
    bit [BUTTONS-1:0]  btn_levels   [PAD_COUNT];
    bit [TIME_W-1:0]   repeat_due   [PAD_COUNT][BUTTONS];
    bit signed [15:0]  last_stick   [PAD_COUNT][STICK_AXES];
    bit [7:0]          last_trigger [PAD_COUNT][2];

    pad_event_t expected_events[$];

    // stimulus-side view of each pad, so random reports form plausible sequences
    bit                stim_online [PAD_COUNT];
    logic [15:0]       stim_buttons[PAD_COUNT];
    report_t           stim_last   [PAD_COUNT];
    logic [TIME_W-1:0] stim_tick;

    // run bookkeeping
    int  failures;
    int  reports_accepted;
    int  events_checked;
    int  repeats_seen;
    int  reg_writes;
    int  cycle_count;
    bit  steady;          // no idling on either side
    bit  hold_request;    // ask the event side for a long hold-off

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // register write mirror: out of range indexes are dropped
    // ------------------------------------------------------------------
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_LEFT_DZ:     shadow_cfg.left_dz     = data[14:0];
            REG_RIGHT_DZ:    shadow_cfg.right_dz    = data[14:0];
            REG_TRIG_THR:    shadow_cfg.trig_thr    = data[7:0];
            REG_FIRST_DELAY: shadow_cfg.first_delay = data;
            REG_NEXT_DELAY:  shadow_cfg.next_delay  = data;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // event prediction for one accepted report
    // ------------------------------------------------------------------
    function automatic void predict_pad_events(input report_t r);
        int unsigned       digital_src[10] = '{12, 13, 14, 15, 8, 9, 4, 5, 6, 7};
        int                axis[AXES];
        int                dz[AXES];
        int                old_value;
        int                magnitude;
        int                i;
        logic [15:0]       bw;
        logic [BUTTONS-1:0] levels;
        logic [BUTTONS-1:0] held_before;
        logic [TIME_W-1:0] lag;
        logic              cur;
        logic              was;
        pad_event_t        batch[$];
        pad_event_t        ev;

        if (int'(r.pad) >= PAD_COUNT)
            return;
        cur = r.connected;
        was = pad_online[r.pad];
        pad_online[r.pad] = cur;
        // a pad that stays offline is silent and keeps its history
        if (!cur && !was)
            return;

        // an offline pad reads as all zeros
        bw      = cur ? r.button_word : 16'h0000;
        axis[0] = cur ? int'(r.left_x)  : 0;
        axis[1] = cur ? int'(r.left_y)  : 0;
        axis[2] = cur ? int'(r.right_x) : 0;
        axis[3] = cur ? int'(r.right_y) : 0;
        axis[4] = cur ? int'(r.left_trigger)  : 0;
        axis[5] = cur ? int'(r.right_trigger) : 0;
        dz[0]   = int'(shadow_cfg.left_dz);
        dz[1]   = dz[0];
        dz[2]   = int'(shadow_cfg.right_dz);
        dz[3]   = dz[2];
        dz[4]   = int'(shadow_cfg.trig_thr);
        dz[5]   = dz[4];

        if (cur && !was)
            batch.push_back('{r.pad, EV_CONNECT, '0, '0, 1'b0});
        else if (!cur && was)
            batch.push_back('{r.pad, EV_DISCONNECT, '0, '0, 1'b0});

        // logical buttons: face, shoulders, start/back swapped, thumbs, triggers,
        // dpad, then stick directions
        levels = '0;
        for (i = 0; i < 10; i++)
            levels[i] = bw[digital_src[i]];
        levels[10] = axis[4] > dz[4];
        levels[11] = axis[5] > dz[5];
        for (i = 0; i < 4; i++)
            levels[12 + i] = bw[i];
        levels[16] = axis[1] > dz[1];
        levels[17] = axis[1] < -dz[1];
        levels[18] = axis[0] < -dz[0];
        levels[19] = axis[0] > dz[0];
        levels[20] = axis[3] > dz[3];
        levels[21] = axis[3] < -dz[3];
        levels[22] = axis[2] < -dz[2];
        levels[23] = axis[2] > dz[2];

        // analog axes: reported on change or beyond deadzone
        for (i = 0; i < AXES; i++)
        begin
            if (i < STICK_AXES)
                old_value = int'(last_stick[r.pad][i]);
            else
                old_value = int'(last_trigger[r.pad][i - STICK_AXES]);
            magnitude = (axis[i] < 0) ? -axis[i] : axis[i];
            if (old_value != axis[i] || magnitude > dz[i])
                batch.push_back('{r.pad, EV_ANALOG, KEY_W'(i), 16'(axis[i]), 1'b0});
            if (i < STICK_AXES)
                last_stick[r.pad][i] = 16'(axis[i]);
            else
                last_trigger[r.pad][i - STICK_AXES] = 8'(axis[i]);
        end

        // edges and auto-repeat, repeat times compared by wrapped difference
        held_before = btn_levels[r.pad];
        for (i = 0; i < BUTTONS; i++)
        begin
            if (levels[i] != held_before[i])
            begin
                batch.push_back('{r.pad, levels[i] ? EV_PRESS : EV_RELEASE, KEY_W'(i), '0,
                                  1'b0});
                if (levels[i])
                    repeat_due[r.pad][i] = r.now + TIME_W'(shadow_cfg.first_delay);
            end
            else if (levels[i])
            begin
                lag = r.now - repeat_due[r.pad][i];
                if (!lag[TIME_W-1])
                begin
                    batch.push_back('{r.pad, EV_REPEAT, KEY_W'(i), '0, 1'b0});
                    repeat_due[r.pad][i] = r.now + TIME_W'(shadow_cfg.next_delay);
                end
            end
        end
        btn_levels[r.pad] = levels;

        for (i = 0; i < batch.size(); i++)
        begin
            ev      = batch[i];
            ev.last = (i == batch.size() - 1);
            expected_events.push_back(ev);
        end
    endfunction

    // ------------------------------------------------------------------
    // compare one observed event with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_event();
        pad_event_t want;

        if (expected_events.size() == 0)
        begin
            $error("unexpected event: pad %0d kind %0d key %0d axis_value %0d last %0d",
                   event_bus.event_pad, event_bus.event_kind, event_bus.key,
                   event_bus.axis_value, event_bus.last);
            failures++;
            return;
        end
        want = expected_events.pop_front();
        events_checked++;
        if (want.kind == EV_REPEAT)
            repeats_seen++;
        if (event_bus.event_pad !== want.pad)
        begin
            $error("event_pad mismatch: expected %0d, actual %0d", want.pad,
                   event_bus.event_pad);
            failures++;
        end
        if (event_bus.event_kind !== want.kind)
        begin
            $error("event_kind mismatch: expected %0d, actual %0d", want.kind,
                   event_bus.event_kind);
            failures++;
        end
        if (event_bus.key !== want.key)
        begin
            $error("key mismatch: expected %0d, actual %0d", want.key, event_bus.key);
            failures++;
        end
        if (event_bus.axis_value !== want.value)
        begin
            $error("axis_value mismatch: expected %0d, actual %0d", want.value,
                   event_bus.axis_value);
            failures++;
        end
        if (event_bus.last !== want.last)
        begin
            $error("last mismatch: expected %0d, actual %0d", want.last, event_bus.last);
            failures++;
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: all three handshakes are sampled at the rising edge;
    // register writes first, then predictions, then checks
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                apply_register(cfg_bus.index, cfg_bus.data);
                reg_writes++;
            end
            if (report_bus.valid && report_bus.ready)
            begin
                predict_pad_events('{report_bus.pad, report_bus.connected,
                                     report_bus.button_word, report_bus.left_trigger,
                                     report_bus.right_trigger, report_bus.left_x,
                                     report_bus.left_y, report_bus.right_x,
                                     report_bus.right_y, report_bus.now});
                reports_accepted++;
            end
            if (event_bus.valid && event_bus.ready)
                check_event();
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events still expected", cycle_count,
                     expected_events.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // event side: random stall bursts, plus one long hold-off
    // counted here when asked for
    // ------------------------------------------------------------------
    initial
    begin : event_ready_driver
        int stall_left;
        int hold_left;

        stall_left = 0;
        hold_left  = 0;
        event_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (!rst_n)
                event_bus.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                event_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                event_bus.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                event_bus.ready <= 1'b0;
            end
            else
                event_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------

    // offer one report, with an occasional gap before it;
    // valid stays up after the accept so back-to-back items need one assignment
    task automatic send_report(input report_t r);
        int gap;

        gap = (!steady && $urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            report_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        report_bus.valid         <= 1'b1;
        report_bus.pad           <= r.pad;
        report_bus.connected     <= r.connected;
        report_bus.button_word   <= r.button_word;
        report_bus.left_trigger  <= r.left_trigger;
        report_bus.right_trigger <= r.right_trigger;
        report_bus.left_x        <= r.left_x;
        report_bus.left_y        <= r.left_y;
        report_bus.right_x       <= r.right_x;
        report_bus.right_y       <= r.right_y;
        report_bus.now           <= r.now;
        do
            @(posedge clk);
        while (!report_bus.ready);
    endtask

    // drop valid, wait for every predicted event, then let the block drain
    task automatic wait_idle();
        @(negedge clk);
        report_bus.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_all_registers(input logic [15:0] left_dz, input logic [15:0] right_dz,
                                       input logic [15:0] thr, input logic [15:0] first_delay,
                                       input logic [15:0] next_delay);
        write_register(REG_LEFT_DZ, left_dz);
        write_register(REG_RIGHT_DZ, right_dz);
        write_register(REG_TRIG_THR, thr);
        write_register(REG_FIRST_DELAY, first_delay);
        write_register(REG_NEXT_DELAY, next_delay);
    endtask

    function automatic report_t pad_report(input logic [1:0] pad, input logic conn,
                                           input logic [15:0] buttons, input logic [7:0] lt,
                                           input logic [7:0] rt, input int lx, input int ly,
                                           input int rx, input int ry,
                                           input logic [TIME_W-1:0] tick);
        report_t r;

        r.pad           = pad;
        r.connected     = conn;
        r.button_word   = buttons;
        r.left_trigger  = lt;
        r.right_trigger = rt;
        r.left_x        = 16'(lx);
        r.left_y        = 16'(ly);
        r.right_x       = 16'(rx);
        r.right_y       = 16'(ry);
        r.now           = tick;
        return r;
    endfunction

    // stick sample biased toward the deadzone edges, the rails and no change
    function automatic logic signed [15:0] pick_axis(input logic signed [15:0] prev,
                                                     input int dz);
        case ($urandom_range(0, 9))
            0:       return 16'sd0;
            1, 2:    return prev;
            3:       return 16'sh7FFF;
            4:       return 16'sh8000;
            5:       return 16'(dz);
            6:       return 16'(-dz);
            7:       return 16'(dz + 1);
            8:       return 16'(int'($urandom_range(0, 2 * dz)) - dz);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] pick_trigger(input logic [7:0] prev, input int thr);
        case ($urandom_range(0, 6))
            0:       return 8'd0;
            1, 2:    return prev;
            3:       return 8'hFF;
            4:       return 8'(thr);
            5:       return 8'(thr + 1);
            default: return 8'($urandom());
        endcase
    endfunction

    // mostly a plausible next poll of a random pad: held buttons change a bit
    // at a time and the tick moves forward; now and then pure noise
    function automatic report_t random_report();
        report_t     r;
        logic [1:0]  p;

        if ($urandom_range(0, 24) == 0)
        begin
            r.pad           = 2'($urandom());
            r.connected     = 1'($urandom());
            r.button_word   = 16'($urandom());
            r.left_trigger  = 8'($urandom());
            r.right_trigger = 8'($urandom());
            r.left_x        = 16'($urandom());
            r.left_y        = 16'($urandom());
            r.right_x       = 16'($urandom());
            r.right_y       = 16'($urandom());
            r.now           = $urandom();
            return r;
        end
        p = 2'($urandom_range(0, PAD_COUNT - 1));
        stim_tick = stim_tick + TIME_W'($urandom_range(0, 120));
        if ($urandom_range(0, 19) == 0)
            stim_online[p] = !stim_online[p];
        if ($urandom_range(0, 2) == 0)
            stim_buttons[p] = stim_buttons[p] ^ (16'h0001 << $urandom_range(0, 15));
        else if ($urandom_range(0, 29) == 0)
            stim_buttons[p] = 16'($urandom());
        r.pad           = p;
        r.connected     = stim_online[p];
        r.button_word   = stim_buttons[p];
        r.left_trigger  = pick_trigger(stim_last[p].left_trigger, int'(shadow_cfg.trig_thr));
        r.right_trigger = pick_trigger(stim_last[p].right_trigger, int'(shadow_cfg.trig_thr));
        r.left_x        = pick_axis(stim_last[p].left_x, int'(shadow_cfg.left_dz));
        r.left_y        = pick_axis(stim_last[p].left_y, int'(shadow_cfg.left_dz));
        r.right_x       = pick_axis(stim_last[p].right_x, int'(shadow_cfg.right_dz));
        r.right_y       = pick_axis(stim_last[p].right_y, int'(shadow_cfg.right_dz));
        r.now           = stim_tick;
        stim_last[p]    = r;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // connect, field extremes, deadzone and threshold edges, disconnect,
    // a pad that was never online
    task automatic test_connect_and_extremes();
        send_report(pad_report(2'd0, 1'b1, 16'h0000, 8'd0, 8'd0, 0, 0, 0, 0, 100));
        send_report(pad_report(2'd1, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, -32768, 32767, -32768,
                               32767, 110));
        send_report(pad_report(2'd0, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, -32768, 32767, -32768,
                               32767, 120));
        // every stick direction flips to the other side
        send_report(pad_report(2'd0, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 32767, -32768, 32767,
                               -32768, 130));
        // sitting exactly on the deadzone and threshold
        send_report(pad_report(2'd0, 1'b1, 16'h0000, 8'd30, 8'd31, 7849, -7849, 8689, -8689,
                               140));
        send_report(pad_report(2'd0, 1'b1, 16'h0000, 8'd30, 8'd31, 7850, -7850, 8690, -8690,
                               150));
        // disconnect releases everything held; a second offline poll is silent
        send_report(pad_report(2'd0, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 1, 1, 1, 1, 160));
        send_report(pad_report(2'd0, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 1, 1, 1, 1, 170));
        send_report(pad_report(2'd1, 1'b1, 16'h5A5A, 8'd0, 8'd200, 100, -100, 0, 0, 180));
        send_report(pad_report(2'd2, 1'b1, 16'hA5A5, 8'd90, 8'd0, 0, 0, -9000, 9000, 190));
        send_report(pad_report(2'd3, 1'b1, 16'h0C00, 8'd0, 8'd0, 0, 0, 0, 0, 200));
    endtask

    // first and next repeat delays at their exact boundaries, then across time wrap
    task automatic test_repeat_timing();
        send_report(pad_report(2'd2, 1'b1, 16'h1000, 8'd0, 8'd0, 0, 0, 0, 0, 1000));
        send_report(pad_report(2'd2, 1'b1, 16'h1000, 8'd0, 8'd0, 0, 0, 0, 0, 1199));
        send_report(pad_report(2'd2, 1'b1, 16'h1000, 8'd0, 8'd0, 0, 0, 0, 0, 1200));
        send_report(pad_report(2'd2, 1'b1, 16'h1000, 8'd0, 8'd0, 0, 0, 0, 0, 1299));
        send_report(pad_report(2'd2, 1'b1, 16'h1000, 8'd0, 8'd0, 0, 0, 0, 0, 1300));
        // A looks far in the future after the jump, B wraps past zero
        send_report(pad_report(2'd2, 1'b1, 16'h3000, 8'd0, 8'd0, 0, 0, 0, 0, 32'hFFFF_FF80));
        send_report(pad_report(2'd2, 1'b1, 16'h3000, 8'd0, 8'd0, 0, 0, 0, 0, 32'h0000_0050));
    endtask

    // all registers at zero, then all at full scale; writes to unused indexes
    task automatic test_register_extremes();
        int idx;

        wait_idle();
        for (idx = int'(REG_NEXT_DELAY) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_register(CFG_IDX_W'(idx), 16'hFFFF);
        write_all_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // zero deadzones: any nonzero sample is a direction, zero delays repeat at once
        send_report(pad_report(2'd3, 1'b1, 16'h0000, 8'd1, 8'd1, 1, -1, -1, 1, 5000));
        send_report(pad_report(2'd3, 1'b1, 16'h0000, 8'd1, 8'd1, 1, -1, -1, 1, 5000));
        wait_idle();
        // upper bits of the narrow registers are dropped
        write_all_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_report(pad_report(2'd3, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, -32768, -32768, 32767,
                               32767, 6000));
        send_report(pad_report(2'd3, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, -32768, -32768, 32767,
                               32767, 6000 + 65535));
    endtask

    // random polls in phases, each under its own register setting
    task automatic test_random_traffic();
        int phase;
        int k;

        for (k = 0; k < PAD_COUNT; k++)
        begin
            stim_online[k]  = 1'b1;
            stim_buttons[k] = 16'h0000;
            stim_last[k]    = pad_report(2'(k), 1'b1, 16'h0000, 8'd0, 8'd0, 0, 0, 0, 0, 0);
        end
        stim_tick = 32'd200000;
        for (phase = 0; phase < 3; phase++)
        begin
            wait_idle();
            write_register(CFG_IDX_W'($urandom_range(int'(REG_NEXT_DELAY) + 1,
                                                     (1 << CFG_IDX_W) - 1)), 16'($urandom()));
            case (phase)
                0: write_all_registers(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                       16'($urandom_range(0, 400)), 16'($urandom()));
                1: write_all_registers(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                       16'($urandom_range(0, 300)),
                                       16'($urandom_range(0, 300)));
                default: write_all_registers(16'(LEFT_DZ_RST), 16'(RIGHT_DZ_RST),
                                             16'(TRIG_THR_RST), FIRST_DELAY_RST,
                                             NEXT_DELAY_RST);
            endcase
            for (k = 0; k < 70; k++)
                send_report(random_report());
        end
    endtask

    // event side held off for a long stretch while full-swing reports keep coming
    task automatic test_event_backpressure();
        int  k;
        bit  swing;

        hold_request = 1'b1;
        for (k = 0; k < 12; k++)
        begin
            swing     = ((k / PAD_COUNT) % 2) == 0;
            stim_tick = stim_tick + 32'd50;
            send_report(pad_report(2'(k % PAD_COUNT), 1'b1, swing ? 16'hFFFF : 16'h0000,
                                   swing ? 8'hFF : 8'h00, swing ? 8'hFF : 8'h00,
                                   swing ? -32768 : 32767, swing ? 32767 : -32768,
                                   swing ? -32768 : 32767, swing ? 32767 : -32768,
                                   stim_tick));
        end
    endtask

    // closing stretch with both sides always ready
    task automatic test_steady_stream();
        int k;

        steady = 1'b1;
        for (k = 0; k < 30; k++)
            send_report(random_report());
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n                    = 1'b0;
        steady                   = 1'b0;
        hold_request             = 1'b0;
        failures                 = 0;
        reports_accepted         = 0;
        events_checked           = 0;
        repeats_seen             = 0;
        reg_writes               = 0;
        cycle_count              = 0;
        report_bus.valid         = 1'b0;
        report_bus.pad           = '0;
        report_bus.connected     = 1'b0;
        report_bus.button_word   = '0;
        report_bus.left_trigger  = '0;
        report_bus.right_trigger = '0;
        report_bus.left_x        = '0;
        report_bus.left_y        = '0;
        report_bus.right_x       = '0;
        report_bus.right_y       = '0;
        report_bus.now           = '0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.index            = '0;
        cfg_bus.data             = '0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_connect_and_extremes();
        test_repeat_timing();
        test_register_extremes();
        test_random_traffic();
        test_event_backpressure();
        test_steady_stream();
        wait_idle();

        $display("covered %0d reports, %0d events checked (%0d auto-repeats)",
                 reports_accepted, events_checked, repeats_seen);
        $display("%0d register writes, %0d mismatches", reg_writes, failures);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/gre_pkg.sv
rtl/gre_report_if.sv
rtl/gre_event_if.sv
rtl/gre_cfg_if.sv
rtl/gre_ram.sv
rtl/gre_cfg.sv
rtl/gre_ctl.sv
rtl/gre_dp.sv
rtl/gamepad_report_event_generator.sv
test/gamepad_report_event_generator_tb.sv
